>>> rtl/indexed_doubly_linked_list_assert.svh
// assertion macros shared by the list block
`ifndef INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IDLL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list check failed");

// next-cycle implication, checked out of reset
`define IDLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list check failed");

`endif

>>> rtl/idll_pkg.sv
`default_nettype none
package idll_pkg;

	localparam int POOL_SIZE = 16;
	localparam int VALUE_W   = 32;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int PTR_W     = $clog2(POOL_SIZE + 1);

	// pointer value meaning no node
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SIZE);

	typedef enum logic {
		REQ_INSERT,
		REQ_DELETE
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_EMPTY,
		ST_FULL
	} status_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [4:0]         position;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed_value;
		logic [4:0]         list_length;
	} rsp_t;

	typedef struct packed {
		logic             full;
		logic [IDX_W-1:0] index;
	} free_t;

endpackage
`default_nettype wire

>>> rtl/idll_free_find.sv
`default_nettype none
module idll_free_find import idll_pkg::*; (
	input  wire logic [POOL_SIZE-1:0] in_use,
	output free_t                     free
);

	// lowest-numbered free node wins
	always_comb begin
		free.full  = 1'b1;
		free.index = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (!in_use[i]) begin
				free.full  = 1'b0;
				free.index = IDX_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/indexed_doubly_linked_list.sv
// channel   | ports              | handshake
// request   | start, busy, req   | word taken when start high and busy low
// result    | done, rsp          | one-cycle strobe, receiver cannot stall
//
// errors finish straight from idle; a position-0 delete goes through S_DEL_WR and a position-0
// insert through S_INS_A and S_INS_B; a request at position p > 0 first walks in S_WALK.
// the walk follows one forward link per cycle through the next-pointer memory,
// so the longest request is an insert at position 15 into a list of 15.
// busy rises once a request that does not end in an error is accepted and falls as done pulses.
// reset empties the list at once; node memories need no clearing.
`default_nettype none
module indexed_doubly_linked_list import idll_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_INS_A,
		S_INS_B,
		S_DEL_WR
	} state_t;

	state_t                 state_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       count_q;
	logic [POOL_SIZE-1:0]   in_use_q;
	logic [PTR_W-1:0]       cur_q;
	logic [PTR_W-1:0]       steps_q;
	logic [PTR_W-1:0]       p_q;
	logic [PTR_W-1:0]       n_q;
	logic [IDX_W-1:0]       f_q;
	logic [IDX_W-1:0]       victim_q;
	logic [VALUE_W-1:0]     val_q;
	req_type_t              type_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic [PTR_W-1:0]       node_next [POOL_SIZE];
	logic [PTR_W-1:0]       node_prev [POOL_SIZE];
	logic [VALUE_W-1:0]     node_value [POOL_SIZE];
	logic [PTR_W-1:0]       nrd_q;
	logic [PTR_W-1:0]       prd_q;
	logic [VALUE_W-1:0]     vrd_q;

	logic [IDX_W-1:0]       rd_addr;
	logic                   nwe, pwe, vwe;
	logic [IDX_W-1:0]       nwa, pwa, vwa;
	logic [PTR_W-1:0]       nwd, pwd;
	logic [VALUE_W-1:0]     vwd;
	logic                   accept;
	free_t                  free;

	idll_free_find u_free (
		.in_use (in_use_q),
		.free   (free)
	);

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// idle reads at the head, the walk reads at the link just fetched
	always_comb begin
		rd_addr = head_q[IDX_W-1:0];
		if (state_q == S_WALK)
			rd_addr = nrd_q[IDX_W-1:0];
	end

	always_comb begin
		nwe = 1'b0; nwa = '0; nwd = '0;
		pwe = 1'b0; pwa = '0; pwd = '0;
		vwe = 1'b0; vwa = '0; vwd = '0;
		case (state_q)
			S_INS_A: begin
				nwe = 1'b1; nwa = f_q; nwd = n_q;
				pwe = 1'b1; pwa = f_q; pwd = p_q;
				vwe = 1'b1; vwa = f_q; vwd = val_q;
			end
			S_INS_B: begin
				pwe = (n_q != NULL_PTR); pwa = n_q[IDX_W-1:0]; pwd = PTR_W'(f_q);
				nwe = (p_q != NULL_PTR); nwa = p_q[IDX_W-1:0]; nwd = PTR_W'(f_q);
			end
			S_DEL_WR: begin
				// unlink the victim using its own forward and backward links
				nwe = (prd_q != NULL_PTR); nwa = prd_q[IDX_W-1:0]; nwd = nrd_q;
				pwe = (nrd_q != NULL_PTR); pwa = nrd_q[IDX_W-1:0]; pwd = prd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nwe)
			node_next[nwa] <= nwd;
		nrd_q <= node_next[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pwe)
			node_prev[pwa] <= pwd;
		prd_q <= node_prev[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vwe)
			node_value[vwa] <= vwd;
		vrd_q <= node_value[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= NULL_PTR;
			count_q  <= '0;
			in_use_q <= '0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						type_q  <= req.req_type;
						val_q   <= VALUE_W'(req.new_value);
						f_q     <= free.index;
						cur_q   <= head_q;
						steps_q <= req.position - PTR_W'(1);
						rsp_q.removed_value <= '0;
						rsp_q.list_length   <= count_q;
						if (req.req_type == REQ_INSERT) begin
							if (req.position > count_q) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
							end else if (count_q == PTR_W'(POOL_SIZE) || free.full) begin
								rsp_q.status <= ST_FULL;
								done_q       <= 1'b1;
							end else if (req.position == '0) begin
								p_q     <= NULL_PTR;
								n_q     <= head_q;
								state_q <= S_INS_A;
							end else begin
								state_q <= S_WALK;
							end
						end else begin
							if (count_q == '0) begin
								rsp_q.status <= ST_EMPTY;
								done_q       <= 1'b1;
							end else if (req.position >= count_q) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
							end else if (req.position == '0) begin
								victim_q <= head_q[IDX_W-1:0];
								state_q  <= S_DEL_WR;
							end else begin
								state_q <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (steps_q == '0) begin
						// cur_q is the node before the position, nrd_q its successor
						if (type_q == REQ_INSERT) begin
							p_q     <= cur_q;
							n_q     <= nrd_q;
							state_q <= S_INS_A;
						end else begin
							victim_q <= nrd_q[IDX_W-1:0];
							state_q  <= S_DEL_WR;
						end
					end else begin
						cur_q   <= nrd_q;
						steps_q <= steps_q - PTR_W'(1);
					end
				end
				S_INS_A: begin
					in_use_q[f_q] <= 1'b1;
					state_q       <= S_INS_B;
				end
				S_INS_B: begin
					if (p_q == NULL_PTR)
						head_q <= PTR_W'(f_q);
					count_q             <= count_q + PTR_W'(1);
					rsp_q.status        <= ST_OK;
					rsp_q.removed_value <= '0;
					rsp_q.list_length   <= count_q + PTR_W'(1);
					done_q              <= 1'b1;
					state_q             <= S_IDLE;
				end
				S_DEL_WR: begin
					if (prd_q == NULL_PTR)
						head_q <= nrd_q;
					in_use_q[victim_q]  <= 1'b0;
					count_q             <= count_q - PTR_W'(1);
					rsp_q.status        <= ST_OK;
					rsp_q.removed_value <= vrd_q[31:0];
					rsp_q.list_length   <= count_q - PTR_W'(1);
					done_q              <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "indexed_doubly_linked_list_assert.svh"

	// the free map and the length agree, bar the cycle between claiming a node and counting it
	`IDLL_ASSERT_NOW(a_count_matches_map, state_q != S_INS_B, $countones(in_use_q) == count_q)
	// a word either finishes at once or keeps the block busy
	`IDLL_ASSERT_NEXT(a_accept_progress, accept, busy || done)
	// a result only shows once the sequencer is back in idle
	`IDLL_ASSERT_NOW(a_done_when_idle, done, !busy)
	// an empty list has no head
	`IDLL_ASSERT_NOW(a_empty_no_head, count_q == '0, head_q == NULL_PTR)

endmodule
`default_nettype wire

>>> test/list_result_checker.sv
module list_result_checker import idll_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   words_pending
);

	rsp_t               expected_results[$];
	logic [VALUE_W-1:0] node_val  [POOL_SIZE];
	logic [PTR_W-1:0]   link_fwd  [POOL_SIZE];
	logic [PTR_W-1:0]   link_back [POOL_SIZE];
	bit                 slot_used [POOL_SIZE];
	logic [PTR_W-1:0]   head;
	int unsigned        entries;

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("checker: %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	// node reached after following the given number of forward links from the head
	function automatic logic [PTR_W-1:0] node_at(input int unsigned steps);
		logic [PTR_W-1:0] cur;
		cur = head;
		for (int unsigned i = 0; i < steps && cur < NULL_PTR; i++)
			cur = link_fwd[cur];
		return cur;
	endfunction

	function automatic void relink_back(input logic [PTR_W-1:0] node, input logic [PTR_W-1:0] link);
		if (node < NULL_PTR)
			link_back[node] = link;
	endfunction

	// applies one request word to the list copy and returns the result it gives
	function automatic rsp_t update_list(input req_t r);
		rsp_t             o;
		int               free_slot;
		logic [PTR_W-1:0] cur;
		logic [PTR_W-1:0] victim;
		o = '0;
		o.status = ST_OK;
		if (r.req_type == REQ_INSERT) begin
			if (r.position > entries) begin
				o.status = ST_RANGE;
			end else if (entries >= POOL_SIZE) begin
				o.status = ST_FULL;
			end else begin
				free_slot = 0;
				while (free_slot < POOL_SIZE && slot_used[free_slot])
					free_slot++;
				if (free_slot >= POOL_SIZE) begin
					o.status = ST_FULL;
				end else begin
					slot_used[free_slot] = 1'b1;
					node_val[free_slot] = VALUE_W'(r.new_value);
					if (r.position == 0 || head >= NULL_PTR) begin
						link_fwd[free_slot] = head;
						link_back[free_slot] = NULL_PTR;
						relink_back(head, PTR_W'(free_slot));
						head = PTR_W'(free_slot);
					end else begin
						cur = node_at(r.position - 1);
						if (cur >= NULL_PTR) begin
							slot_used[free_slot] = 1'b0;
							o.status = ST_RANGE;
						end else begin
							link_fwd[free_slot] = link_fwd[cur];
							link_back[free_slot] = cur;
							relink_back(link_fwd[cur], PTR_W'(free_slot));
							link_fwd[cur] = PTR_W'(free_slot);
						end
					end
					if (o.status == ST_OK)
						entries++;
				end
			end
		end else begin
			if (entries == 0 || head >= NULL_PTR) begin
				o.status = ST_EMPTY;
			end else if (r.position >= entries) begin
				o.status = ST_RANGE;
			end else begin
				if (r.position == 0) begin
					victim = head;
					head = link_fwd[victim];
					relink_back(head, NULL_PTR);
				end else begin
					cur = node_at(r.position - 1);
					victim = (cur < NULL_PTR) ? link_fwd[cur] : NULL_PTR;
					if (victim < NULL_PTR) begin
						link_fwd[cur] = link_fwd[victim];
						relink_back(link_fwd[victim], cur);
					end
				end
				if (victim < NULL_PTR) begin
					o.removed_value = node_val[victim][31:0];
					slot_used[victim] = 1'b0;
					entries--;
				end else begin
					o.status = ST_RANGE;
				end
			end
		end
		o.list_length = 5'(entries);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			expected_results.delete();
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			head = NULL_PTR;
			entries = 0;
			words_pending <= 0;
		end else begin
			// the result of the previous word is checked before a word taken on this edge
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected, length", rsp.list_length, 0);
				end else begin
					want = expected_results.pop_front();
					if (rsp.status != want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.removed_value != want.removed_value)
						report_mismatch("removed value", rsp.removed_value, want.removed_value);
					if (rsp.list_length != want.list_length)
						report_mismatch("list length", rsp.list_length, want.list_length);
				end
			end
			if (start && !busy)
				expected_results.push_back(update_list(req));
			words_pending <= expected_results.size();
		end
	end

endmodule

>>> test/tb.sv
module tb;
	import idll_pkg::*;

	localparam int ITEMS = 1200;
	localparam int LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   words_pending;
	int   cycle_count = 0;
	int   list_len;  // length as the sender sees it, used to aim positions
	bit   grow;
	bit   no_idle;

	indexed_doubly_linked_list i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	list_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void track_length(input req_t w);
		if (w.req_type == REQ_INSERT) begin
			if (w.position <= list_len && list_len < POOL_SIZE)
				list_len++;
		end else if (list_len > 0 && w.position < list_len) begin
			list_len--;
		end
	endfunction

	function automatic req_t make_word(input req_type_t kind, input int pos, input logic [31:0] value);
		req_t w;
		w.req_type = kind;
		w.position = 5'(pos);
		w.new_value = value;
		return w;
	endfunction

	function automatic req_t random_word();
		req_t w;
		int   pick;
		pick = $urandom_range(0, 99);
		w.req_type = ((grow && pick < 70) || (!grow && pick < 30)) ? REQ_INSERT : REQ_DELETE;
		pick = $urandom_range(0, 99);
		// a few positions anywhere in the field, mostly beyond the list
		if (pick < 8)
			w.position = 5'($urandom_range(0, 31));
		else if (w.req_type == REQ_INSERT)
			w.position = 5'($urandom_range(0, list_len));
		else
			w.position = 5'($urandom_range(0, (list_len > 0) ? list_len - 1 : 0));
		case ($urandom_range(0, 15))
			0:       w.new_value = 32'h8000_0000;
			1:       w.new_value = 32'h7fff_ffff;
			2:       w.new_value = 32'hffff_ffff;
			3:       w.new_value = 32'h0;
			default: w.new_value = $urandom;
		endcase
		return w;
	endfunction

	// start stays high from one word to the next when there is no gap
	task automatic send_word(input req_t w, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		track_length(w);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	initial begin
		req_t directed_words[$];
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		list_len = 0;
		grow = 1'b1;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		directed_words.push_back(make_word(REQ_DELETE, 0, 32'h1234_5678));
		directed_words.push_back(make_word(REQ_DELETE, 31, 32'h0));
		directed_words.push_back(make_word(REQ_INSERT, 1, 32'h1));
		directed_words.push_back(make_word(REQ_INSERT, 0, 32'h8000_0000));
		directed_words.push_back(make_word(REQ_INSERT, 1, 32'h7fff_ffff));
		directed_words.push_back(make_word(REQ_INSERT, 1, 32'hffff_ffff));
		directed_words.push_back(make_word(REQ_INSERT, 0, 32'h0));
		directed_words.push_back(make_word(REQ_INSERT, 31, 32'hdead_beef));
		directed_words.push_back(make_word(REQ_INSERT, 4, 32'h5555_aaaa));
		directed_words.push_back(make_word(REQ_INSERT, 6, 32'haaaa_5555));
		directed_words.push_back(make_word(REQ_DELETE, 5, 32'h0));
		directed_words.push_back(make_word(REQ_DELETE, 16, 32'hffff_ffff));
		directed_words.push_back(make_word(REQ_DELETE, 4, 32'h0));
		directed_words.push_back(make_word(REQ_DELETE, 1, 32'h0));
		directed_words.push_back(make_word(REQ_DELETE, 0, 32'h0));
		directed_words.push_back(make_word(REQ_DELETE, 1, 32'h0));
		directed_words.push_back(make_word(REQ_DELETE, 0, 32'h0));
		directed_words.push_back(make_word(REQ_DELETE, 0, 32'h0));
		directed_words.push_back(make_word(REQ_INSERT, 0, 32'h0bad_cafe));
		directed_words.push_back(make_word(REQ_DELETE, 0, 32'h0));
		foreach (directed_words[i])
			send_word(directed_words[i], $urandom_range(0, 18));

		for (int n = 0; n < ITEMS; n++) begin
			// phases of growth or shrinkage so the pool both fills and empties
			if (n % 40 == 0) begin
				grow = (n == 0) ? 1'b1 : 1'($urandom_range(0, 1));
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (n % 300 == 150)
				wait_all_results();
			send_word(random_word(), no_idle ? 0 : $urandom_range(0, 18));
		end

		wait_all_results();
		repeat (25) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
